FILE: rtl/core/elx_pkg.sv
// Shared types, constants and the reserved-word lookup of the expression lexer.
// No dependencies.
package elx_pkg;

   localparam int unsigned POS_MAX  = 2047;
   localparam int unsigned LEN_MAX  = 2048;
   localparam int unsigned LINE_CAP = 1048574;
   localparam int unsigned QDEPTH   = 4;

   localparam logic [5:0] K_END     = 6'd0;
   localparam logic [5:0] K_INT     = 6'd1;
   localparam logic [5:0] K_FLOAT   = 6'd2;
   localparam logic [5:0] K_IDENT   = 6'd3;
   localparam logic [5:0] K_BANDNUM = 6'd4;
   localparam logic [5:0] K_PLUS    = 6'd5;
   localparam logic [5:0] K_MINUS   = 6'd6;
   localparam logic [5:0] K_STAR    = 6'd7;
   localparam logic [5:0] K_SLASH   = 6'd8;
   localparam logic [5:0] K_CARET   = 6'd9;
   localparam logic [5:0] K_COMMA   = 6'd10;
   localparam logic [5:0] K_LPAR    = 6'd11;
   localparam logic [5:0] K_RPAR    = 6'd12;
   localparam logic [5:0] K_LBRK    = 6'd13;
   localparam logic [5:0] K_RBRK    = 6'd14;
   localparam logic [5:0] K_LBRC    = 6'd15;
   localparam logic [5:0] K_RBRC    = 6'd16;
   localparam logic [5:0] K_QUEST   = 6'd17;
   localparam logic [5:0] K_COLON   = 6'd18;
   localparam logic [5:0] K_EQ      = 6'd19;
   localparam logic [5:0] K_LT      = 6'd20;
   localparam logic [5:0] K_GT      = 6'd21;
   localparam logic [5:0] K_LE      = 6'd22;
   localparam logic [5:0] K_GE      = 6'd23;
   localparam logic [5:0] K_NE      = 6'd24;
   localparam logic [5:0] K_NOT     = 6'd25;
   localparam logic [5:0] K_AND     = 6'd26;
   localparam logic [5:0] K_OR      = 6'd27;
   localparam logic [5:0] K_BAND    = 6'd28;
   localparam logic [5:0] K_PI      = 6'd29;
   localparam logic [5:0] K_E       = 6'd30;
   localparam logic [5:0] K_NBANDS  = 6'd31;
   localparam logic [5:0] K_SUM     = 6'd32;
   localparam logic [5:0] K_LOG     = 6'd33;
   localparam logic [5:0] K_LOG10   = 6'd34;
   localparam logic [5:0] K_COS     = 6'd35;
   localparam logic [5:0] K_SIN     = 6'd36;
   localparam logic [5:0] K_TAN     = 6'd37;
   localparam logic [5:0] K_ARCCOS  = 6'd38;
   localparam logic [5:0] K_ARCSIN  = 6'd39;
   localparam logic [5:0] K_ARCTAN  = 6'd40;
   localparam logic [5:0] K_TRUNC   = 6'd41;
   localparam logic [5:0] K_ROUND   = 6'd42;
   localparam logic [5:0] K_MIN     = 6'd43;
   localparam logic [5:0] K_MAX     = 6'd44;
   localparam logic [5:0] K_MEDIAN  = 6'd45;

   localparam logic [1:0] E_NONE    = 2'd0;
   localparam logic [1:0] E_POINT   = 2'd1;
   localparam logic [1:0] E_EXP     = 2'd2;
   localparam logic [1:0] E_SYMBOL  = 2'd3;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [5:0]         kind;
      logic [1:0]         error_code;
      logic [10:0]        start_position;
      logic [11:0]        token_length;
      logic signed [31:0] int_value;
      logic [19:0]        line_number;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic [2:0] level;
      logic       full;
   } qstat_type;

   function automatic logic [5:0] rw_lookup(input logic [5:0][7:0] w, input logic [2:0] n);
      logic [5:0] k;
      k = K_END;
      unique case (n)
         3'd1: begin
            if (w[0] == "b") k = K_BAND;
            else if (w[0] == "e") k = K_E;
         end
         3'd2: begin
            if ({w[0], w[1]} == "or") k = K_OR;
            else if ({w[0], w[1]} == "pi") k = K_PI;
         end
         3'd3: begin
            unique case ({w[0], w[1], w[2]})
               "not": k = K_NOT;
               "and": k = K_AND;
               "sum": k = K_SUM;
               "log": k = K_LOG;
               "cos": k = K_COS;
               "sin": k = K_SIN;
               "tan": k = K_TAN;
               "min": k = K_MIN;
               "max": k = K_MAX;
               default: k = K_END;
            endcase
         end
         3'd4: begin
            if ({w[0], w[1], w[2], w[3]} == "band") k = K_BAND;
         end
         3'd5: begin
            unique case ({w[0], w[1], w[2], w[3], w[4]})
               "log10": k = K_LOG10;
               "trunc": k = K_TRUNC;
               "round": k = K_ROUND;
               default: k = K_END;
            endcase
         end
         3'd6: begin
            unique case ({w[0], w[1], w[2], w[3], w[4], w[5]})
               "nbands": k = K_NBANDS;
               "arccos": k = K_ARCCOS;
               "arcsin": k = K_ARCSIN;
               "arctan": k = K_ARCTAN;
               "median": k = K_MEDIAN;
               default:  k = K_END;
            endcase
         end
         default: k = K_END;
      endcase
      return k;
   endfunction

endpackage

FILE: rtl/core/elx_scan.sv
// Front end of the lexer: scanner state machine, up to two tokens per character.
// Depends on elx_pkg.
module elx_scan (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             mode,
   input  elx_pkg::req_type req,
   output elx_pkg::push_type push
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_LT      = 4'd1;
   localparam logic [3:0] S_GT      = 4'd2;
   localparam logic [3:0] S_EQ      = 4'd3;
   localparam logic [3:0] S_BANG    = 4'd4;
   localparam logic [3:0] S_AMP     = 4'd5;
   localparam logic [3:0] S_BAR     = 4'd6;
   localparam logic [3:0] S_MINUS   = 4'd7;
   localparam logic [3:0] S_WORD    = 4'd8;
   localparam logic [3:0] S_INT     = 4'd9;
   localparam logic [3:0] S_POINT   = 4'd10;
   localparam logic [3:0] S_FRAC    = 4'd11;
   localparam logic [3:0] S_EXP     = 4'd12;
   localparam logic [3:0] S_EXPSIGN = 4'd13;
   localparam logic [3:0] S_EXPDIG  = 4'd14;

   localparam logic [31:0] MAG_CAP = 32'h8000_0000;

   logic [3:0]       st_ff, st_in;
   logic [10:0]      tstart_ff, tstart_in;
   logic [11:0]      len_ff, len_in;
   logic [10:0]      col_ff, col_in;
   logic [19:0]      line_ff, line_in;
   logic [31:0]      acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic [5:0][7:0]  wc_ff, wc_in;
   logic             wov_ff, wov_in;
   logic [2:0]       bps_ff, bps_in;
   logic             inc_ff, inc_in;
   logic             hlt_ff, hlt_in;

   function automatic logic [11:0] grow(input logic [11:0] n);
      return (n < 12'(elx_pkg::LEN_MAX)) ? n + 12'd1 : n;
   endfunction

   function automatic logic [31:0] acc_step(input logic [31:0] a, input logic [7:0] c);
      logic [35:0] t;
      t = ({4'd0, a} << 3) + ({4'd0, a} << 1) + {32'd0, c[3:0]};
      return (t > {4'd0, MAG_CAP}) ? MAG_CAP : t[31:0];
   endfunction

   function automatic logic [31:0] pos_val(input logic [31:0] a);
      return (a >= MAG_CAP) ? 32'h7FFF_FFFF : a;
   endfunction

   logic [7:0]        c;
   logic              dig, alpha, space, ex;
   logic              a_v, b_v, consumed;
   elx_pkg::rsp_type  ra, rb;
   logic [19:0]       ln;
   logic [5:0]        rwk, k1;

   function automatic elx_pkg::rsp_type mk(input logic [5:0] k, input logic [1:0] e,
                                           input logic [10:0] s, input logic [11:0] n,
                                           input logic [31:0] v, input logic [19:0] l);
      elx_pkg::rsp_type r;
      r.kind = k;
      r.error_code = e;
      r.start_position = s;
      r.token_length = n;
      r.int_value = v;
      r.line_number = l;
      r.last = 1'b0;
      return r;
   endfunction

   always_comb begin
      c     = req.ch;
      dig   = (c >= "0") && (c <= "9");
      alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
      space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
      ex    = (c == "e") || (c == "E");
      ln    = mode ? line_ff + 20'd1 : 20'd0;
      rwk   = elx_pkg::rw_lookup(wc_ff, len_ff[2:0]);

      st_in = st_ff; tstart_in = tstart_ff; len_in = len_ff; col_in = col_ff;
      line_in = line_ff; acc_in = acc_ff; neg_in = neg_ff; wc_in = wc_ff;
      wov_in = wov_ff; bps_in = bps_ff; inc_in = inc_ff; hlt_in = hlt_ff;
      a_v = 1'b0; b_v = 1'b0; consumed = 1'b0;
      ra = mk(elx_pkg::K_END, elx_pkg::E_NONE, tstart_ff, len_ff, 32'd0, ln);
      rb = ra;
      k1 = elx_pkg::K_END;

      if (accept) begin
         if (!req.end_of_input && !hlt_ff && !inc_ff) begin
            consumed = 1'b1;
            unique case (st_ff)
               S_LT: begin
                  if (c == "=") k1 = elx_pkg::K_LE;
                  else if (c == ">") k1 = elx_pkg::K_NE;
               end
               S_GT:   if (c == "=") k1 = elx_pkg::K_GE;
               S_EQ: begin
                  if (c == ">") k1 = elx_pkg::K_GE;
                  else if (c == "<") k1 = elx_pkg::K_LE;
               end
               S_BANG: if (c == "=") k1 = elx_pkg::K_NE;
               S_AMP:  if (c == "&") k1 = elx_pkg::K_AND;
               S_BAR:  if (c == "|") k1 = elx_pkg::K_OR;
               default: k1 = elx_pkg::K_END;
            endcase
            if (k1 != elx_pkg::K_END) begin
               a_v = 1'b1;
               ra = mk(k1, elx_pkg::E_NONE, tstart_ff, grow(len_ff), 32'd0, ln);
               len_in = grow(len_ff);
               st_in = S_IDLE;
            end else begin
               unique case (st_ff)
                  S_MINUS:
                     if (dig) begin
                        neg_in = 1'b1; acc_in = {28'd0, c[3:0]};
                        len_in = grow(len_ff); st_in = S_INT;
                     end else if (c == ".") begin
                        len_in = grow(len_ff); st_in = S_POINT;
                     end else consumed = 1'b0;
                  S_WORD:
                     if (alpha || dig || c == "_") begin
                        if (len_ff < 12'd6) wc_in[len_ff[2:0]] = c;
                        else wov_in = 1'b1;
                        unique case (bps_ff)
                           3'd1:
                              if (c == "a") bps_in = 3'd2;
                              else if (dig) begin
                                 bps_in = 3'd5; acc_in = acc_step(acc_ff, c);
                              end else bps_in = 3'd0;
                           3'd2: bps_in = (c == "n") ? 3'd3 : 3'd0;
                           3'd3: bps_in = (c == "d") ? 3'd4 : 3'd0;
                           3'd4, 3'd5:
                              if (dig) begin
                                 bps_in = 3'd5; acc_in = acc_step(acc_ff, c);
                              end else bps_in = 3'd0;
                           default: bps_in = 3'd0;
                        endcase
                        len_in = grow(len_ff);
                     end else consumed = 1'b0;
                  S_INT:
                     if (dig) begin
                        acc_in = acc_step(acc_ff, c); len_in = grow(len_ff);
                     end else if (c == ".") begin
                        len_in = grow(len_ff); st_in = S_POINT;
                     end else if (ex) begin
                        len_in = grow(len_ff); st_in = S_EXP;
                     end else consumed = 1'b0;
                  S_POINT:
                     if (dig) begin
                        len_in = grow(len_ff); st_in = S_FRAC;
                     end else consumed = 1'b0;
                  S_FRAC:
                     if (dig) len_in = grow(len_ff);
                     else if (ex) begin
                        len_in = grow(len_ff); st_in = S_EXP;
                     end else consumed = 1'b0;
                  S_EXP:
                     if (c == "-") begin
                        len_in = grow(len_ff); st_in = S_EXPSIGN;
                     end else if (dig) begin
                        len_in = grow(len_ff); st_in = S_EXPDIG;
                     end else consumed = 1'b0;
                  S_EXPSIGN, S_EXPDIG:
                     if (dig) begin
                        len_in = grow(len_ff); st_in = S_EXPDIG;
                     end else consumed = 1'b0;
                  default: consumed = 1'b0;
               endcase
            end
         end

         // close the pending token at end of input or when the character did not extend it
         if (!hlt_ff && (req.end_of_input || (!inc_ff && !consumed))) begin
            st_in = S_IDLE;
            unique case (st_ff)
               S_LT:    begin a_v = 1'b1; ra.kind = elx_pkg::K_LT; end
               S_GT:    begin a_v = 1'b1; ra.kind = elx_pkg::K_GT; end
               S_EQ:    begin a_v = 1'b1; ra.kind = elx_pkg::K_EQ; end
               S_BANG:  begin a_v = 1'b1; ra.kind = elx_pkg::K_NOT; end
               S_MINUS: begin a_v = 1'b1; ra.kind = elx_pkg::K_MINUS; end
               S_AMP, S_BAR: begin
                  a_v = 1'b1; hlt_in = 1'b1;
                  ra.error_code = elx_pkg::E_SYMBOL; ra.token_length = 12'd1;
               end
               S_WORD: begin
                  a_v = 1'b1;
                  if (!wov_ff && len_ff <= 12'd6 && rwk != elx_pkg::K_END) ra.kind = rwk;
                  else if (bps_ff == 3'd5) begin
                     ra.kind = elx_pkg::K_BANDNUM; ra.int_value = pos_val(acc_ff);
                  end else ra.kind = elx_pkg::K_IDENT;
               end
               S_INT: begin
                  a_v = 1'b1; ra.kind = elx_pkg::K_INT;
                  ra.int_value = neg_ff ? 32'd0 - acc_ff : pos_val(acc_ff);
               end
               S_POINT: begin
                  a_v = 1'b1; hlt_in = 1'b1; ra.error_code = elx_pkg::E_POINT;
               end
               S_FRAC, S_EXPDIG: begin a_v = 1'b1; ra.kind = elx_pkg::K_FLOAT; end
               S_EXP, S_EXPSIGN: begin
                  a_v = 1'b1; hlt_in = 1'b1; ra.error_code = elx_pkg::E_EXP;
               end
               default: a_v = 1'b0;
            endcase
         end

         if (req.end_of_input) begin
            b_v = 1'b1;
            rb = mk(elx_pkg::K_END, elx_pkg::E_NONE, col_ff, 12'd0, 32'd0, ln);
            st_in = S_IDLE; tstart_in = '0; len_in = '0; col_in = '0; line_in = '0;
            acc_in = '0; neg_in = 1'b0; wov_in = 1'b0; bps_in = '0;
            inc_in = 1'b0; hlt_in = 1'b0;
         end else if (!hlt_ff) begin
            if (!inc_ff && !consumed && !hlt_in) begin
               k1 = elx_pkg::K_END;
               case (c)
                  "+": k1 = elx_pkg::K_PLUS;
                  "*": k1 = elx_pkg::K_STAR;
                  "/": k1 = elx_pkg::K_SLASH;
                  "^": k1 = elx_pkg::K_CARET;
                  ",": k1 = elx_pkg::K_COMMA;
                  "(": k1 = elx_pkg::K_LPAR;
                  ")": k1 = elx_pkg::K_RPAR;
                  "[": k1 = elx_pkg::K_LBRK;
                  "]": k1 = elx_pkg::K_RBRK;
                  "{": k1 = elx_pkg::K_LBRC;
                  "}": k1 = elx_pkg::K_RBRC;
                  "?": k1 = elx_pkg::K_QUEST;
                  ":": k1 = elx_pkg::K_COLON;
                  default: k1 = elx_pkg::K_END;
               endcase
               if (space) begin
               end else if (c == "#" || c == 8'd0) begin
                  inc_in = 1'b1;
               end else if (k1 != elx_pkg::K_END) begin
                  b_v = 1'b1;
                  rb = mk(k1, elx_pkg::E_NONE, col_ff, 12'd1, 32'd0, ln);
               end else if (c == "<" || c == ">" || c == "=" || c == "!" || c == "&" ||
                            c == "|" || c == "-" || c == "." || alpha || dig) begin
                  tstart_in = col_ff; len_in = 12'd1; acc_in = '0; neg_in = 1'b0;
                  case (c)
                     "<": st_in = S_LT;
                     ">": st_in = S_GT;
                     "=": st_in = S_EQ;
                     "!": st_in = S_BANG;
                     "&": st_in = S_AMP;
                     "|": st_in = S_BAR;
                     "-": st_in = S_MINUS;
                     ".": st_in = S_POINT;
                     default: st_in = alpha ? S_WORD : S_INT;
                  endcase
                  if (alpha) begin
                     wc_in[0] = c; wov_in = 1'b0;
                     bps_in = (c == "b") ? 3'd1 : 3'd0;
                  end
                  if (dig) acc_in = {28'd0, c[3:0]};
               end else begin
                  b_v = 1'b1; hlt_in = 1'b1; st_in = S_IDLE;
                  rb = mk(elx_pkg::K_END, elx_pkg::E_SYMBOL, col_ff, 12'd1, 32'd0, ln);
               end
            end
            if (mode && c == 8'h0A) begin
               if (line_ff < 20'(elx_pkg::LINE_CAP)) line_in = line_ff + 20'd1;
               col_in = '0;
               inc_in = 1'b0;
            end else if (col_ff < 11'(elx_pkg::POS_MAX)) begin
               col_in = col_ff + 11'd1;
            end
         end
      end

      rb.last = 1'b1;
      ra.last = !b_v;
      push.count  = {1'b0, a_v} + {1'b0, b_v};
      push.first  = a_v ? ra : rb;
      push.second = rb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; tstart_ff <= '0; len_ff <= '0; col_ff <= '0; line_ff <= '0;
         acc_ff <= '0; neg_ff <= 1'b0; wov_ff <= 1'b0; bps_ff <= '0;
         inc_ff <= 1'b0; hlt_ff <= 1'b0;
      end else begin
         st_ff <= st_in; tstart_ff <= tstart_in; len_ff <= len_in; col_ff <= col_in;
         line_ff <= line_in; acc_ff <= acc_in; neg_ff <= neg_in; wov_ff <= wov_in;
         bps_ff <= bps_in; inc_ff <= inc_in; hlt_ff <= hlt_in;
      end
   end

   always_ff @(posedge clock) begin
      wc_ff <= wc_in;
   end

endmodule

FILE: rtl/core/elx_queue.sv
// Back end of the lexer: four-entry token queue that delivers one token a cycle unless the receiver stalls.
// Depends on elx_pkg.
module elx_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_en,
   input  elx_pkg::push_type   push,
   output elx_pkg::qstat_type  stat,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output elx_pkg::rsp_type    rsp
);

   elx_pkg::rsp_type mem_ff [elx_pkg::QDEPTH];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;
   logic [1:0] n;

   always_comb begin
      n      = push_en ? push.count : 2'd0;
      pop    = (cnt_ff != 3'd0) && !rsp_stall;
      wr_in  = wr_ff + n;
      rd_in  = rd_ff + {1'b0, pop};
      cnt_in = cnt_ff + {1'b0, n} - {2'd0, pop};
      rsp_valid  = cnt_ff != 3'd0;
      rsp        = mem_ff[rd_ff];
      stat.level = cnt_ff;
      stat.full  = cnt_ff > 3'(elx_pkg::QDEPTH - 2);
   end

   always_ff @(posedge clock) begin
      if (n != 2'd0) mem_ff[wr_ff] <= push.first;
      if (n == 2'd2) mem_ff[wr_ff + 2'd1] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: rtl/core/expression_char_lexer_top.sv
// Expression character lexer, top level: scanner front end and token queue.
// Depends on elx_pkg, elx_scan and elx_queue.
//
// One character is taken per cycle unless the request side stalls; a character
// yields zero, one or two tokens, which pass through a four-entry queue that
// delivers one token per cycle unless the receiver stalls. The request side
// stalls while the queue holds more than two tokens.
module expression_char_lexer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  elx_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output elx_pkg::rsp_type rsp,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   logic                mode_ff;
   logic                accept;
   elx_pkg::push_type   push;
   elx_pkg::qstat_type  stat;

   assign csr_ready = 1'b1;
   assign req_stall = stat.full;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   elx_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .mode   (mode_ff),
      .req    (req),
      .push   (push)
   );

   elx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (accept),
      .push      (push),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   a_level: assert property (@(posedge clock) disable iff (reset)
      stat.level <= 3'(elx_pkg::QDEPTH))
      else $error("token queue overflow");

   a_end: assert property (@(posedge clock) disable iff (reset)
      accept && req.end_of_input |=> rsp_valid)
      else $error("end of input gave no token");

   a_push: assert property (@(posedge clock) disable iff (reset)
      accept |-> push.count != 2'd3)
      else $error("more than two tokens from one character");

endmodule

FILE: tb/expression_char_lexer_top_tb.sv
// Self-checking testbench for expression_char_lexer_top: drives character requests,
// predicts the token stream in SystemVerilog and checks every delivered token.
// Depends on elx_pkg and the lexer RTL.
module expression_char_lexer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import elx_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LT, S_GT, S_EQ, S_BANG, S_AMP, S_BAR, S_MINUS, S_WORD,
      S_INT, S_POINT, S_FRAC, S_EXP, S_EXPSIGN, S_EXPDIG
   } scan_type;

   localparam logic [63:0] MAG_CAP = 64'd2147483648;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   expression_char_lexer_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   req_type  pending_chars[$];
   rsp_type  expected_tokens[$];
   int       error_count = 0;
   int       csr_writes = 0;

   // lexer state as seen by the predictor
   logic        file_mode = 1'b0;
   scan_type    st;
   logic [10:0] tok_start;
   logic [11:0] len_cnt;
   logic [10:0] col_cnt;
   logic [19:0] line_cnt;
   logic [63:0] acc;
   logic        neg;
   logic [7:0]  wchars[6];
   logic        overlong;
   logic [2:0]  bstate;
   logic        in_cmt;
   logic        halted;
   rsp_type     out_buf[2];
   int          n_out;

   string words[22] = '{"band", "b", "not", "and", "or", "pi", "e", "nbands", "sum",
      "log", "log10", "cos", "sin", "tan", "arccos", "arcsin", "arctan", "trunc",
      "round", "min", "max", "median"};
   string ops[30] = '{"+", "-", "*", "/", "^", ",", "(", ")", "[", "]", "{", "}", "?",
      ":", "=", "<", ">", "<=", "=<", ">=", "=>", "<>", "!=", "!", "&&", "||", "-7",
      "-.5", "<<", "=="};

   function automatic void clear_scan();
      st = S_IDLE; tok_start = '0; len_cnt = '0; col_cnt = '0; line_cnt = '0;
      acc = '0; neg = 1'b0; overlong = 1'b0; bstate = '0; in_cmt = 1'b0; halted = 1'b0;
      foreach (wchars[i]) wchars[i] = '0;
   endfunction

   function automatic void emit_token(logic [5:0] k, logic [1:0] e, logic [10:0] s,
                                      logic [11:0] l, logic [31:0] v);
      rsp_type t;
      if (n_out >= 2) return;
      t.kind = k; t.error_code = e; t.start_position = s; t.token_length = l;
      t.int_value = v; t.line_number = file_mode ? line_cnt + 20'd1 : 20'd0; t.last = 1'b0;
      out_buf[n_out] = t;
      n_out++;
   endfunction

   function automatic void fail_token(logic [1:0] e, logic [10:0] s, logic [11:0] l);
      emit_token(K_END, e, s, l, '0);
      halted = 1'b1;
      st = S_IDLE;
   endfunction

   function automatic void grow();
      if (len_cnt < LEN_MAX) len_cnt++;
   endfunction

   function automatic void accumulate(logic [7:0] c);
      acc = acc * 10 + (c - 8'h30);
      if (acc > MAG_CAP) acc = MAG_CAP;
   endfunction

   function automatic logic [31:0] clipped_value();
      return (acc >= MAG_CAP) ? 32'h7fffffff : acc[31:0];
   endfunction

   function automatic void close_word();
      string w;
      logic [5:0] k;
      k = K_END;
      if (!overlong && len_cnt <= 6) begin
         w = "";
         for (int i = 0; i < len_cnt; i++) begin
            w = {w, " "};
            w.putc(i, wchars[i]);
         end
         case (w)
            "band", "b": k = K_BAND;
            "not": k = K_NOT;
            "and": k = K_AND;
            "or": k = K_OR;
            "pi": k = K_PI;
            "e": k = K_E;
            "nbands": k = K_NBANDS;
            "sum": k = K_SUM;
            "log": k = K_LOG;
            "log10": k = K_LOG10;
            "cos": k = K_COS;
            "sin": k = K_SIN;
            "tan": k = K_TAN;
            "arccos": k = K_ARCCOS;
            "arcsin": k = K_ARCSIN;
            "arctan": k = K_ARCTAN;
            "trunc": k = K_TRUNC;
            "round": k = K_ROUND;
            "min": k = K_MIN;
            "max": k = K_MAX;
            "median": k = K_MEDIAN;
            default: k = K_END;
         endcase
      end
      if (k != K_END) emit_token(k, E_NONE, tok_start, len_cnt, '0);
      else if (bstate == 3'd5) emit_token(K_BANDNUM, E_NONE, tok_start, len_cnt, clipped_value());
      else emit_token(K_IDENT, E_NONE, tok_start, len_cnt, '0);
   endfunction

   function automatic void flush_pending();
      case (st)
         S_LT: emit_token(K_LT, E_NONE, tok_start, len_cnt, '0);
         S_GT: emit_token(K_GT, E_NONE, tok_start, len_cnt, '0);
         S_EQ: emit_token(K_EQ, E_NONE, tok_start, len_cnt, '0);
         S_BANG: emit_token(K_NOT, E_NONE, tok_start, len_cnt, '0);
         S_MINUS: emit_token(K_MINUS, E_NONE, tok_start, len_cnt, '0);
         S_AMP, S_BAR: fail_token(E_SYMBOL, tok_start, 12'd1);
         S_WORD: close_word();
         S_INT: emit_token(K_INT, E_NONE, tok_start, len_cnt,
                           neg ? 32'd0 - acc[31:0] : clipped_value());
         S_POINT: fail_token(E_POINT, tok_start, len_cnt);
         S_FRAC, S_EXPDIG: emit_token(K_FLOAT, E_NONE, tok_start, len_cnt, '0);
         S_EXP, S_EXPSIGN: fail_token(E_EXP, tok_start, len_cnt);
         default: ;
      endcase
      st = S_IDLE;
   endfunction

   function automatic bit pair_op(logic [5:0] k);
      grow();
      emit_token(k, E_NONE, tok_start, len_cnt, '0);
      st = S_IDLE;
      return 1'b1;
   endfunction

   function automatic bit advance(scan_type s);
      grow();
      st = s;
      return 1'b1;
   endfunction

   function automatic void word_append(logic [7:0] c);
      bit dig;
      dig = c >= "0" && c <= "9";
      if (len_cnt < 6) wchars[len_cnt] = c;
      else overlong = 1'b1;
      case (bstate)
         3'd1: begin
            if (c == "a") bstate = 3'd2;
            else if (dig) begin bstate = 3'd5; accumulate(c); end
            else bstate = 3'd0;
         end
         3'd2: bstate = (c == "n") ? 3'd3 : 3'd0;
         3'd3: bstate = (c == "d") ? 3'd4 : 3'd0;
         3'd4, 3'd5: begin
            if (dig) begin bstate = 3'd5; accumulate(c); end
            else bstate = 3'd0;
         end
         default: bstate = 3'd0;
      endcase
      grow();
   endfunction

   // true when the character is used up by the pending token or closing that token halts the lexer
   function automatic bit offer_pending(logic [7:0] c);
      bit dig, ex, alpha;
      dig = c >= "0" && c <= "9";
      ex = c == "e" || c == "E";
      alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      case (st)
         S_LT: begin
            if (c == "=") return pair_op(K_LE);
            if (c == ">") return pair_op(K_NE);
         end
         S_GT: if (c == "=") return pair_op(K_GE);
         S_EQ: begin
            if (c == ">") return pair_op(K_GE);
            if (c == "<") return pair_op(K_LE);
         end
         S_BANG: if (c == "=") return pair_op(K_NE);
         S_AMP: if (c == "&") return pair_op(K_AND);
         S_BAR: if (c == "|") return pair_op(K_OR);
         S_MINUS: begin
            if (dig) begin
               neg = 1'b1; acc = {56'd0, c - 8'h30};
               return advance(S_INT);
            end
            if (c == ".") return advance(S_POINT);
         end
         S_WORD: if (alpha || dig || c == "_") begin word_append(c); return 1'b1; end
         S_INT: begin
            if (dig) begin accumulate(c); return advance(S_INT); end
            if (c == ".") return advance(S_POINT);
            if (ex) return advance(S_EXP);
         end
         S_POINT: if (dig) return advance(S_FRAC);
         S_FRAC: begin
            if (dig) return advance(S_FRAC);
            if (ex) return advance(S_EXP);
         end
         S_EXP: begin
            if (c == "-") return advance(S_EXPSIGN);
            if (dig) return advance(S_EXPDIG);
         end
         S_EXPSIGN, S_EXPDIG: if (dig) return advance(S_EXPDIG);
         default: begin st = S_IDLE; return 1'b0; end
      endcase
      flush_pending();
      return halted;
   endfunction

   function automatic void open_token(scan_type s, logic [10:0] col);
      st = s; tok_start = col; len_cnt = 12'd1; acc = '0; neg = 1'b0;
   endfunction

   function automatic void start_token(logic [7:0] c, logic [10:0] col);
      logic [5:0] k;
      k = K_END;
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
      if (c == "#" || c == 8'd0) begin in_cmt = 1'b1; return; end
      case (c)
         "+": k = K_PLUS;
         "*": k = K_STAR;
         "/": k = K_SLASH;
         "^": k = K_CARET;
         ",": k = K_COMMA;
         "(": k = K_LPAR;
         ")": k = K_RPAR;
         "[": k = K_LBRK;
         "]": k = K_RBRK;
         "{": k = K_LBRC;
         "}": k = K_RBRC;
         "?": k = K_QUEST;
         ":": k = K_COLON;
         "<": begin open_token(S_LT, col); return; end
         ">": begin open_token(S_GT, col); return; end
         "=": begin open_token(S_EQ, col); return; end
         "!": begin open_token(S_BANG, col); return; end
         "&": begin open_token(S_AMP, col); return; end
         "|": begin open_token(S_BAR, col); return; end
         "-": begin open_token(S_MINUS, col); return; end
         ".": begin open_token(S_POINT, col); return; end
         default: ;
      endcase
      if (k != K_END) begin emit_token(k, E_NONE, col, 12'd1, '0); return; end
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
         open_token(S_WORD, col);
         wchars[0] = c; overlong = 1'b0;
         bstate = (c == "b") ? 3'd1 : 3'd0;
         return;
      end
      if (c >= "0" && c <= "9") begin
         open_token(S_INT, col);
         acc = {56'd0, c - 8'h30};
         return;
      end
      fail_token(E_SYMBOL, col, 12'd1);
   endfunction

   function automatic void lex_request(req_type r);
      logic [10:0] col;
      col = col_cnt;
      n_out = 0;
      if (r.end_of_input) begin
         if (!halted) flush_pending();
         emit_token(K_END, E_NONE, col, '0, '0);
         clear_scan();
      end else if (!halted) begin
         if (!in_cmt) begin
            if (!offer_pending(r.ch))
               if (!halted) start_token(r.ch, col);
         end
         if (file_mode && r.ch == 8'd10) begin
            if (line_cnt < LINE_CAP) line_cnt++;
            col_cnt = '0;
            in_cmt = 1'b0;
         end else if (col_cnt < POS_MAX) begin
            col_cnt++;
         end
      end
      if (n_out > 0) out_buf[n_out-1].last = 1'b1;
      for (int i = 0; i < n_out; i++) expected_tokens.push_back(out_buf[i]);
   endfunction

   // driver: bursts of requests with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_scan();
      end else begin
         if (req_valid && !req_stall) lex_request(req);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_chars.size() > 0) begin
               req <= pending_chars.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
                  gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: randomly picks one of three stall patterns, plus a periodic long hold-off
   int cycle_count = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (cycle_count % 1000 >= 800) rsp_stall <= 1'b1;
      else if (stall_mode == 0) rsp_stall <= 1'b0;
      else if (stall_mode == 1) rsp_stall <= $urandom_range(0, 9) < 3;
      else rsp_stall <= $urandom_range(0, 9) < 7;
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none, actual %p", $realtime, rsp);
            error_count++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp !== want) begin
               $display("%0t: token mismatch, expected %p, actual %p", $realtime, want, rsp);
               error_count++;
            end
         end
      end
   end

   // configuration write
   always @(posedge clock) begin
      if (csr_valid && csr_ready) begin
         file_mode = csr_data;
         csr_valid <= 1'b0;
         csr_writes++;
      end
   end

   task automatic push_char(logic [7:0] c);
      req_type r;
      r.ch = c; r.end_of_input = 1'b0;
      pending_chars.push_back(r);
   endtask

   task automatic push_end();
      req_type r;
      r.ch = 8'($urandom); r.end_of_input = 1'b1;
      pending_chars.push_back(r);
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   task automatic push_digits(int lo, int hi);
      repeat ($urandom_range(lo, hi)) push_char(8'(8'h30 + $urandom_range(0, 9)));
   endtask

   task automatic push_space();
      logic [7:0] sp[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
      push_char(sp[$urandom_range(0, 5)]);
   endtask

   task automatic push_sentence();
      int n;
      n = $urandom_range(1, 14);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0: push_text(words[$urandom_range(0, 21)]);
            1: begin
               push_char(8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25)));
               repeat ($urandom_range(0, 3) == 0 ? $urandom_range(6, 12) : $urandom_range(0, 5))
                  case ($urandom_range(0, 3))
                     0: push_char(8'("0" + $urandom_range(0, 9)));
                     1: push_char("_");
                     2: push_char(8'("A" + $urandom_range(0, 25)));
                     default: push_char(8'("a" + $urandom_range(0, 25)));
                  endcase
            end
            2: begin
               push_text($urandom_range(0, 1) ? "b" : "band");
               push_digits(1, 11);
            end
            3: begin
               if ($urandom_range(0, 2) == 0) push_char("-");
               push_digits(1, 12);
            end
            4: begin
               if ($urandom_range(0, 1)) push_digits(1, 3);
               push_char(".");
               push_digits(1, 3);
               if ($urandom_range(0, 1)) begin
                  push_char($urandom_range(0, 1) ? "e" : "E");
                  if ($urandom_range(0, 1)) push_char("-");
                  push_digits(1, 2);
               end
            end
            5, 6: push_text(ops[$urandom_range(0, 29)]);
            7: case ($urandom_range(0, 7))
               0: push_text("1.");
               1: push_text("1e");
               2: push_text("2e-x");
               3: push_text(".");
               4: push_text("&");
               5: push_text("|");
               default: push_text("4e2");
            endcase
            8: begin
               push_char($urandom_range(0, 3) == 0 ? 8'd0 : "#");
               repeat ($urandom_range(0, 8)) push_char(8'($urandom_range(1, 255)));
               push_char(8'd10);
            end
            default: ;
         endcase
         if ($urandom_range(0, 3) != 0) push_space();
         if ($urandom_range(0, 60) == 0) push_char(8'($urandom_range(0, 255)));
      end
      push_end();
   endtask

   task automatic drain();
      while (pending_chars.size() > 0 || req_valid || expected_tokens.size() > 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_mode(logic v);
      int done;
      done = csr_writes;
      @(posedge clock);
      csr_data <= v;
      csr_valid <= 1'b1;
      while (csr_writes == done) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      int target;
      target = pending_chars.size() + count;
      while (pending_chars.size() < target) push_sentence();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      push_text("a<=b>=c<>d!=e=<f=>g&&h||i!j=k<l>m and or not");
      push_end();
      push_text("+-*/^,()[]{}?: pi e nbands sum log log10 cos sin tan");
      push_end();
      push_text("arccos arcsin arctan trunc round min max median band b x_9");
      push_end();
      push_text("99999999999 -2147483648 -99999999999 2147483647 b2147483648 band7 bandx");
      push_end();
      push_text("-.5e-3 1.5E2 x-3 ."); push_end();
      push_text("1."); push_end();
      push_text("1e-"); push_end();
      push_text("a&b"); push_end();
      push_text("|"); push_end();
      push_text("q"); push_char(8'd200); push_end();
      push_text("7"); push_char(8'd0); push_text("skipped 9"); push_end();
      drain();
      write_mode(1'b1);
      push_text("x # note\n y=1\n\n#c\n 3.e"); push_end();
      random_phase(400);
      drain();
      write_mode(1'b0);
      random_phase(400);
      drain();
      write_mode(1'b1);
      random_phase(400);
      drain();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: expression_char_lexer_top.f
rtl/core/elx_pkg.sv
rtl/core/elx_scan.sv
rtl/core/elx_queue.sv
rtl/core/expression_char_lexer_top.sv
tb/expression_char_lexer_top_tb.sv
